[design/pmcr_pkg.sv]
// Package for the paged memory clock replacement block.
// Holds sizes, field widths, codes and the sequencer state type.
// No dependencies.
package pmcr_pkg;

  localparam int PROCESSES         = 4;
  localparam int PAGES_PER_PROCESS = 256;
  localparam int FRAMES            = 64;
  localparam int MAX_QUOTA         = 4;

  localparam int PROC_W  = 2;
  localparam int PAGE_W  = 8;
  localparam int FRAME_W = 6;
  localparam int SLOT_W  = 2;
  localparam int SIDX_W  = PROC_W + SLOT_W;
  localparam int PTA_W   = PROC_W + PAGE_W;
  localparam int PTD_W   = 1 + SLOT_W;
  localparam int CNT_W   = 3;
  localparam int PSIZE_W = 13;
  localparam int OFF_W   = 12;
  localparam int PHYS_W  = 18;
  localparam int PROD_W  = FRAME_W + PSIZE_W;
  localparam int STAT_W  = 3;

  localparam logic [1:0] KIND_READ    = 2'd0;
  localparam logic [1:0] KIND_WRITE   = 2'd1;
  localparam logic [1:0] KIND_SUSPEND = 2'd2;
  localparam logic [1:0] KIND_FINISH  = 2'd3;

  localparam logic [STAT_W-1:0] ST_HIT      = 3'd0;
  localparam logic [STAT_W-1:0] ST_LOADED   = 3'd1;
  localparam logic [STAT_W-1:0] ST_OFF_ERR  = 3'd2;
  localparam logic [STAT_W-1:0] ST_NO_FRAME = 3'd3;
  localparam logic [STAT_W-1:0] ST_RELEASED = 3'd4;

  localparam logic [1:0] CFG_PAGE_SIZE = 2'd0;
  localparam logic [1:0] CFG_POLICY    = 2'd1;
  localparam logic [1:0] CFG_QUOTA     = 2'd2;
  localparam logic [1:0] CFG_FRAMES    = 2'd3;

  typedef enum logic [10:0] {
    S_CLEAR  = 11'b00000000001,
    S_IDLE   = 11'b00000000010,
    S_LOOK   = 11'b00000000100,
    S_DECIDE = 11'b00000001000,
    S_FREE   = 11'b00000010000,
    S_VIC    = 11'b00000100000,
    S_REPL   = 11'b00001000000,
    S_REPL2  = 11'b00010000000,
    S_REL    = 11'b00100000000,
    S_MUL    = 11'b01000000000,
    S_EMIT   = 11'b10000000000
  } state_t;

endpackage

[design/paged_memory_clock_replacement.sv]
// Top level: page table, resident slots, clock victim search and frame map.
// Depends on pmcr_pkg.
//
// channel   signals                                  handshake
// command   start kind process page offset           start && !busy
// result    status frame phys_addr evict_valid       done, one cycle each
//           evict_page writeback last
// config    cfg_we cfg_index cfg_data                cfg_we
//
// Paths: a hit passes LOOK, DECIDE, MUL and EMIT; an offset error or an empty
// release goes straight to MUL and EMIT; a fault below quota scans for a free
// frame, one frame per cycle; a replacement runs the clock search, one slot per
// cycle, then REPL and REPL2; a release gives one result per frame (REL, MUL, EMIT).
// busy drops with the final result, so the next item can go in at the edge that takes it.
// After reset a clearing pass writes the 1024-entry page table, one entry a
// cycle; busy stays high until the pass ends. Results cannot be stalled.
module paged_memory_clock_replacement (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  output logic                           done,
  input  logic [1:0]                     kind,
  input  logic [pmcr_pkg::PROC_W-1:0]    process,
  input  logic [pmcr_pkg::PAGE_W-1:0]    page,
  input  logic [pmcr_pkg::OFF_W-1:0]     offset,
  input  logic                           cfg_we,
  input  logic [1:0]                     cfg_index,
  input  logic [pmcr_pkg::PSIZE_W-1:0]   cfg_data,
  output logic [pmcr_pkg::STAT_W-1:0]    status,
  output logic [pmcr_pkg::FRAME_W-1:0]   frame,
  output logic [pmcr_pkg::PHYS_W-1:0]    phys_addr,
  output logic                           evict_valid,
  output logic [pmcr_pkg::PAGE_W-1:0]    evict_page,
  output logic                           writeback,
  output logic                           last
);

  localparam int NSLOT = pmcr_pkg::PROCESSES * pmcr_pkg::MAX_QUOTA;
  localparam int NPT   = pmcr_pkg::PROCESSES * pmcr_pkg::PAGES_PER_PROCESS;

  pmcr_pkg::state_t state;

  logic [pmcr_pkg::PSIZE_W-1:0] page_size;
  logic                         replace_policy;
  logic [2:0]                   frame_quota;
  logic [6:0]                   frames_in_memory;

  // page table: present + resident slot
  logic [pmcr_pkg::PTD_W-1:0] pt_mem [NPT];
  logic [pmcr_pkg::PTD_W-1:0] pt_q;
  logic                       pt_we;
  logic [pmcr_pkg::PTA_W-1:0] pt_waddr;
  logic [pmcr_pkg::PTD_W-1:0] pt_wdata;
  logic [pmcr_pkg::PTA_W-1:0] clr_addr;

  logic [pmcr_pkg::PAGE_W-1:0]  sl_page  [NSLOT];
  logic                         sl_use   [NSLOT];
  logic                         sl_mod   [NSLOT];
  logic [pmcr_pkg::FRAME_W-1:0] sl_frame [NSLOT];

  logic [pmcr_pkg::CNT_W-1:0]  res_count  [pmcr_pkg::PROCESSES];
  logic [pmcr_pkg::SLOT_W-1:0] clock_hand [pmcr_pkg::PROCESSES];
  logic [pmcr_pkg::FRAMES-1:0] frame_taken;

  logic [1:0]                  kind_r;
  logic [pmcr_pkg::PROC_W-1:0] p_r;
  logic [pmcr_pkg::PAGE_W-1:0] pg_r;
  logic [pmcr_pkg::OFF_W-1:0]  off_r;
  logic [pmcr_pkg::CNT_W-1:0]  n_r;
  logic [6:0]                  fcnt;
  logic [pmcr_pkg::SLOT_W-1:0] h;
  logic [pmcr_pkg::SLOT_W-1:0] v_r;
  logic [3:0]                  cnt;
  logic                        pass_b;
  logic                        rnd;

  logic [pmcr_pkg::STAT_W-1:0]  r_status;
  logic [pmcr_pkg::FRAME_W-1:0] r_frame;
  logic                         r_ev;
  logic [pmcr_pkg::PAGE_W-1:0]  r_epage;
  logic                         r_wb;
  logic                         r_last;
  logic                         r_addoff;
  logic                         r_zero;
  logic [pmcr_pkg::PROD_W-1:0]  prod;

  logic                         wr;
  logic [2:0]                   q_sat;
  logic [6:0]                   lim;
  logic [pmcr_pkg::SIDX_W-1:0]  hidx;
  logic [pmcr_pkg::SIDX_W-1:0]  vidx;
  logic [pmcr_pkg::SIDX_W-1:0]  pidx;
  logic [pmcr_pkg::SLOT_W-1:0]  h_inc;
  logic                         u_h;
  logic                         m_h;
  logic [pmcr_pkg::PHYS_W-1:0]  phys_sum;

  function automatic logic [pmcr_pkg::PHYS_W-1:0] PHYS_W_CUT(
    input logic [pmcr_pkg::PROD_W-1:0] x);
    PHYS_W_CUT = x[pmcr_pkg::PHYS_W-1:0];
  endfunction

  function automatic logic [pmcr_pkg::PTA_W-1:0] PTA_MAX();
    PTA_MAX = '1;
  endfunction

  assign busy  = (state != pmcr_pkg::S_IDLE);
  assign wr    = (kind_r == pmcr_pkg::KIND_WRITE);
  assign q_sat = (frame_quota == 3'd0) ? 3'd1 :
                 (frame_quota > 3'(pmcr_pkg::MAX_QUOTA)) ? 3'(pmcr_pkg::MAX_QUOTA) :
                 frame_quota;
  assign lim   = (frames_in_memory > 7'(pmcr_pkg::FRAMES)) ? 7'(pmcr_pkg::FRAMES) :
                 frames_in_memory;
  assign hidx  = {p_r, h};
  assign vidx  = {p_r, v_r};
  assign pidx  = {p_r, pt_q[pmcr_pkg::SLOT_W-1:0]};
  assign h_inc = ({1'b0, h} + 3'd1 == n_r) ? '0 : h + 2'd1;
  assign u_h   = sl_use[hidx];
  assign m_h   = sl_mod[hidx];
  assign phys_sum = r_zero ? '0 :
                    PHYS_W_CUT(prod + {7'd0, (r_addoff ? off_r : 12'd0)});

  // page table write port
  always_comb begin
    pt_we    = 1'b0;
    pt_waddr = {p_r, pg_r};
    pt_wdata = '0;
    case (state)
      pmcr_pkg::S_CLEAR: begin
        pt_we    = 1'b1;
        pt_waddr = clr_addr;
      end
      pmcr_pkg::S_FREE: begin
        pt_we    = (fcnt < lim) && !frame_taken[fcnt[pmcr_pkg::FRAME_W-1:0]];
        pt_wdata = {1'b1, n_r[pmcr_pkg::SLOT_W-1:0]};
      end
      pmcr_pkg::S_REPL: begin
        pt_we    = 1'b1;
        pt_waddr = {p_r, sl_page[vidx]};
      end
      pmcr_pkg::S_REPL2: begin
        pt_we    = 1'b1;
        pt_wdata = {1'b1, v_r};
      end
      pmcr_pkg::S_REL: begin
        pt_we    = (n_r != '0);
        pt_waddr = {p_r, sl_page[{p_r, cnt[pmcr_pkg::SLOT_W-1:0]}]};
      end
      default: pt_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pt_we) pt_mem[pt_waddr] <= pt_wdata;
    pt_q <= pt_mem[{p_r, pg_r}];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size        <= 13'd64;
      replace_policy   <= 1'b0;
      frame_quota      <= 3'd4;
      frames_in_memory <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        pmcr_pkg::CFG_PAGE_SIZE: page_size        <= cfg_data;
        pmcr_pkg::CFG_POLICY:    replace_policy   <= cfg_data[0];
        pmcr_pkg::CFG_QUOTA:     frame_quota      <= cfg_data[2:0];
        pmcr_pkg::CFG_FRAMES:    frames_in_memory <= cfg_data[6:0];
        default:                 page_size        <= page_size;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= pmcr_pkg::S_CLEAR;
      clr_addr    <= '0;
      done        <= 1'b0;
      frame_taken <= '0;
      for (int i = 0; i < pmcr_pkg::PROCESSES; i++) begin
        res_count[i]  <= '0;
        clock_hand[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        pmcr_pkg::S_CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == PTA_MAX()) state <= pmcr_pkg::S_IDLE;
        end
        pmcr_pkg::S_IDLE: begin
          if (start) begin
            kind_r   <= kind;
            p_r      <= process;
            pg_r     <= page;
            off_r    <= offset;
            n_r      <= res_count[process];
            r_ev     <= 1'b0;
            r_epage  <= '0;
            r_wb     <= 1'b0;
            r_last   <= 1'b1;
            r_zero   <= 1'b0;
            r_addoff <= 1'b1;
            r_frame  <= '0;
            cnt      <= '0;
            if (kind == pmcr_pkg::KIND_SUSPEND || kind == pmcr_pkg::KIND_FINISH) begin
              if (kind == pmcr_pkg::KIND_SUSPEND) clock_hand[process] <= '0;
              if (res_count[process] == '0) begin
                r_status <= pmcr_pkg::ST_HIT;
                r_zero   <= 1'b1;
                state    <= pmcr_pkg::S_MUL;
              end else begin
                state <= pmcr_pkg::S_REL;
              end
            end else if ({1'b0, offset} >= page_size) begin
              r_status <= pmcr_pkg::ST_OFF_ERR;
              r_zero   <= 1'b1;
              state    <= pmcr_pkg::S_MUL;
            end else begin
              state <= pmcr_pkg::S_LOOK;
            end
          end
        end
        pmcr_pkg::S_LOOK: state <= pmcr_pkg::S_DECIDE;
        pmcr_pkg::S_DECIDE: begin
          if (pt_q[pmcr_pkg::PTD_W-1]) begin
            sl_use[pidx] <= 1'b1;
            if (wr) sl_mod[pidx] <= 1'b1;
            r_frame  <= sl_frame[pidx];
            r_status <= pmcr_pkg::ST_HIT;
            state    <= pmcr_pkg::S_MUL;
          end else if (n_r < q_sat) begin
            fcnt  <= '0;
            state <= pmcr_pkg::S_FREE;
          end else begin
            h      <= ({1'b0, clock_hand[p_r]} < n_r) ? clock_hand[p_r] : '0;
            pass_b <= 1'b0;
            rnd    <= 1'b0;
            state  <= pmcr_pkg::S_VIC;
          end
        end
        pmcr_pkg::S_FREE: begin
          if (fcnt >= lim) begin
            r_status <= pmcr_pkg::ST_NO_FRAME;
            r_zero   <= 1'b1;
            state    <= pmcr_pkg::S_MUL;
          end else if (!frame_taken[fcnt[pmcr_pkg::FRAME_W-1:0]]) begin
            frame_taken[fcnt[pmcr_pkg::FRAME_W-1:0]] <= 1'b1;
            sl_page[{p_r, n_r[pmcr_pkg::SLOT_W-1:0]}]  <= pg_r;
            sl_use[{p_r, n_r[pmcr_pkg::SLOT_W-1:0]}]   <= 1'b1;
            sl_mod[{p_r, n_r[pmcr_pkg::SLOT_W-1:0]}]   <= wr;
            sl_frame[{p_r, n_r[pmcr_pkg::SLOT_W-1:0]}] <= fcnt[pmcr_pkg::FRAME_W-1:0];
            res_count[p_r]  <= n_r + 3'd1;
            clock_hand[p_r] <= ({1'b0, clock_hand[p_r]} + 3'd1 >= q_sat) ? '0 :
                               clock_hand[p_r] + 2'd1;
            r_frame  <= fcnt[pmcr_pkg::FRAME_W-1:0];
            r_status <= pmcr_pkg::ST_LOADED;
            state    <= pmcr_pkg::S_MUL;
          end else begin
            fcnt <= fcnt + 7'd1;
          end
        end
        pmcr_pkg::S_VIC: begin
          // one resident slot examined per cycle
          if (!replace_policy) begin
            if (!u_h) begin
              v_r   <= h;
              state <= pmcr_pkg::S_REPL;
            end else begin
              sl_use[hidx] <= 1'b0;
              h   <= h_inc;
              cnt <= cnt + 4'd1;
              if (cnt == {n_r, 1'b0}) begin
                v_r   <= h_inc;
                state <= pmcr_pkg::S_REPL;
              end
            end
          end else begin
            if (!u_h && (m_h == pass_b)) begin
              v_r   <= h;
              state <= pmcr_pkg::S_REPL;
            end else begin
              if (pass_b) sl_use[hidx] <= 1'b0;
              h   <= h_inc;
              cnt <= cnt + 4'd1;
              if (cnt[pmcr_pkg::CNT_W-1:0] == n_r - 3'd1) begin
                cnt    <= '0;
                pass_b <= !pass_b;
                if (pass_b) begin
                  rnd <= 1'b1;
                  if (rnd) begin
                    v_r   <= h_inc;
                    state <= pmcr_pkg::S_REPL;
                  end
                end
              end
            end
          end
        end
        pmcr_pkg::S_REPL: begin
          r_epage  <= sl_page[vidx];
          r_wb     <= sl_mod[vidx];
          r_frame  <= sl_frame[vidx];
          r_ev     <= 1'b1;
          r_status <= pmcr_pkg::ST_LOADED;
          sl_page[vidx] <= pg_r;
          sl_use[vidx]  <= 1'b1;
          sl_mod[vidx]  <= wr;
          clock_hand[p_r] <= ({1'b0, v_r} + 3'd1 == n_r) ? '0 : v_r + 2'd1;
          state <= pmcr_pkg::S_REPL2;
        end
        pmcr_pkg::S_REPL2: state <= pmcr_pkg::S_MUL;
        pmcr_pkg::S_REL: begin
          r_status <= pmcr_pkg::ST_RELEASED;
          r_frame  <= sl_frame[{p_r, cnt[pmcr_pkg::SLOT_W-1:0]}];
          r_ev     <= 1'b1;
          r_epage  <= sl_page[{p_r, cnt[pmcr_pkg::SLOT_W-1:0]}];
          r_wb     <= (kind_r == pmcr_pkg::KIND_SUSPEND);
          r_last   <= (cnt[pmcr_pkg::CNT_W-1:0] + 3'd1 == n_r);
          r_addoff <= 1'b0;
          frame_taken[sl_frame[{p_r, cnt[pmcr_pkg::SLOT_W-1:0]}]] <= 1'b0;
          state <= pmcr_pkg::S_MUL;
        end
        pmcr_pkg::S_MUL: begin
          prod  <= r_frame * page_size;
          state <= pmcr_pkg::S_EMIT;
        end
        pmcr_pkg::S_EMIT: begin
          status      <= r_status;
          frame       <= r_frame;
          phys_addr   <= phys_sum;
          evict_valid <= r_ev;
          evict_page  <= r_epage;
          writeback   <= r_wb;
          last        <= r_last;
          done        <= 1'b1;
          if (r_status == pmcr_pkg::ST_RELEASED && !r_last) begin
            cnt   <= cnt + 4'd1;
            state <= pmcr_pkg::S_REL;
          end else begin
            if (r_status == pmcr_pkg::ST_RELEASED) res_count[p_r] <= '0;
            state <= pmcr_pkg::S_IDLE;
          end
        end
        default: state <= pmcr_pkg::S_IDLE;
      endcase
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted item did not raise busy");
  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    done && last |-> !busy) else $error("final result while still busy");
  a_more_busy: assert property (@(posedge clk) disable iff (rst)
    done && !last |-> busy) else $error("release sequence stopped early");
  a_hit_noevict: assert property (@(posedge clk) disable iff (rst)
    done && status == pmcr_pkg::ST_HIT |-> !evict_valid)
    else $error("hit reported an eviction");

endmodule
